// File: hdl/fcr_pkg.sv
// ----------------------------------------------------------------------------
// fcr_pkg: shared types and constants of the framed command receiver
// Op codes, result kinds, error codes and the front-to-back job record.
// ----------------------------------------------------------------------------
package fcr_pkg;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_TICK  = 2'd1,
    OP_DIST  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  localparam logic [3:0] K_REPLY   = 4'd0;
  localparam logic [3:0] K_TEXT    = 4'd1;
  localparam logic [3:0] K_NOTE    = 4'd2;
  localparam logic [3:0] K_TCOMMIT = 4'd3;
  localparam logic [3:0] K_MCOMMIT = 4'd4;
  localparam logic [3:0] K_POS     = 4'd5;
  localparam logic [3:0] K_CAM     = 4'd6;
  localparam logic [3:0] K_VICTIM  = 4'd7;
  localparam logic [3:0] K_ERROR   = 4'd8;
  localparam logic [3:0] K_DISCARD = 4'd9;

  localparam logic [2:0] E_CHECK   = 3'd0;
  localparam logic [2:0] E_TYPE    = 3'd1;
  localparam logic [2:0] E_LENGTH  = 3'd2;
  localparam logic [2:0] E_PAYLOAD = 3'd3;
  localparam logic [2:0] E_CHKTO   = 3'd4;

  localparam logic [1:0] REG_LONG   = 2'd0;
  localparam logic [1:0] REG_LENGTH = 2'd1;
  localparam logic [1:0] REG_NOTE   = 2'd2;

  localparam logic [15:0] LONG_RESET   = 16'd3000;
  localparam logic [15:0] LENGTH_RESET = 16'd100;
  localparam logic [15:0] NOTE_RESET   = 16'd200;
  localparam logic [7:0]  NOTE_SEED    = 8'h04;

  // Job classes handed from the parser to the result sequencer.
  typedef enum logic [2:0] {
    J_TEXT    = 3'd0,
    J_NOTE    = 3'd1,
    J_ERROR   = 3'd2,
    J_FINISH  = 3'd3
  } job_e;

  typedef struct packed {
    job_e        job;
    logic [2:0]  ftype;
    logic [7:0]  seq;
    logic [7:0]  val;
    logic [23:0] held;
    logic [15:0] range_mm;
    logic [7:0]  count;
    logic [2:0]  code;
  } job_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  reply_value;
    logic [15:0] word_first;
    logic [15:0] word_second;
    logic [7:0]  heading;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  item_count;
    logic [2:0]  error_code;
    logic        last;
  } result_t;

endpackage

// File: hdl/fcr_front.sv
// ----------------------------------------------------------------------------
// fcr_front: frame parser
// Accepts input beats, tracks the frame phase, check and timers, and
// pushes one job per beat that produces results.
// ----------------------------------------------------------------------------
module fcr_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [1:0]     op_i,
  input  logic [7:0]     rx_byte_i,
  input  logic [15:0]    distance_in_i,
  input  logic [15:0]    long_timeout_i,
  input  logic [15:0]    length_timeout_i,
  input  logic [15:0]    note_timeout_i,
  output logic           job_valid_o,
  output fcr_pkg::job_t  job_o,
  input  logic           job_ready_i
);
  import fcr_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_SEQ, PH_FIXED, PH_LEN, PH_TEXT, PH_NOTES, PH_CHECK
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  ftype_q, ftype_d;
  logic [7:0]  seq_q, seq_d, chk_q, chk_d, rem_q, rem_d, len_q, len_d;
  logic [1:0]  pos_q, pos_d;
  logic [23:0] held_q, held_d;
  logic [15:0] ticks_q, ticks_d, dist_q, dist_d;
  logic        push;
  job_t        job;
  logic [15:0] limit;
  logic [2:0]  tcode;
  logic        timed;
  logic        acc;

  assign in_ready_o = job_ready_i;
  assign acc = in_valid_i && in_ready_o;
  assign job_valid_o = acc && push;
  assign job_o = job;

  always_comb begin
    timed = 1'b1;
    limit = long_timeout_i;
    tcode = E_CHKTO;
    case (phase_q)
      PH_FIXED: begin limit = long_timeout_i; tcode = E_CHKTO; end
      PH_LEN: begin
        limit = (ftype_q == 3'd3) ? length_timeout_i : long_timeout_i;
        tcode = E_LENGTH;
      end
      PH_TEXT:  begin limit = long_timeout_i; tcode = E_PAYLOAD; end
      PH_NOTES: begin limit = note_timeout_i; tcode = E_PAYLOAD; end
      PH_CHECK: begin
        limit = (ftype_q == 3'd3) ? note_timeout_i : long_timeout_i;
        tcode = E_CHKTO;
      end
      default: timed = 1'b0;
    endcase
  end

  always_comb begin
    phase_d = phase_q; ftype_d = ftype_q; seq_d = seq_q; chk_d = chk_q;
    rem_d = rem_q; len_d = len_q; pos_d = pos_q; held_d = held_q;
    ticks_d = ticks_q; dist_d = dist_q;
    push = 1'b0;
    job = '0;
    job.ftype = ftype_q;
    job.seq = seq_q;
    job.held = held_q;
    job.range_mm = dist_q;
    job.count = len_q;
    if (op_i == OP_BYTE) begin
      unique case (phase_q)
        PH_SEQ: begin
          seq_d = rx_byte_i; chk_d = chk_q ^ rx_byte_i;
          ticks_d = '0; pos_d = '0; held_d = '0;
          if (ftype_q == 3'd0) phase_d = PH_CHECK;
          else if (ftype_q == 3'd1 || ftype_q == 3'd4 || ftype_q == 3'd5)
            phase_d = PH_FIXED;
          else if (ftype_q == 3'd2 || ftype_q == 3'd3) phase_d = PH_LEN;
          else begin
            push = 1'b1; job.job = J_ERROR; job.code = E_TYPE;
            phase_d = PH_IDLE;
          end
        end
        PH_LEN: begin
          len_d = rx_byte_i; rem_d = rx_byte_i;
          chk_d = (ftype_q == 3'd3) ? (NOTE_SEED ^ seq_q ^ rx_byte_i)
                                    : (chk_q ^ rx_byte_i);
          ticks_d = '0;
          if (rx_byte_i == 8'd0) phase_d = PH_CHECK;
          else phase_d = (ftype_q == 3'd2) ? PH_TEXT : PH_NOTES;
        end
        PH_TEXT: begin
          chk_d = chk_q ^ rx_byte_i;
          push = 1'b1; job.job = J_TEXT; job.val = rx_byte_i;
          rem_d = rem_q - 8'd1; ticks_d = '0;
          if (rem_q == 8'd1) phase_d = PH_CHECK;
        end
        PH_NOTES: begin
          chk_d = chk_q ^ rx_byte_i;
          if (pos_q != 2'd3) begin
            held_d = {held_q[15:0], rx_byte_i};
            pos_d = pos_q + 2'd1;
          end else begin
            push = 1'b1; job.job = J_NOTE; job.val = rx_byte_i;
            pos_d = '0; held_d = '0; rem_d = rem_q - 8'd1; ticks_d = '0;
            if (rem_q == 8'd1) phase_d = PH_CHECK;
          end
        end
        PH_FIXED: begin
          chk_d = chk_q ^ rx_byte_i;
          held_d = {held_q[15:0], rx_byte_i};
          if (pos_q == 2'd2) begin
            pos_d = '0; phase_d = PH_CHECK;
          end else begin
            pos_d = pos_q + 2'd1;
          end
        end
        PH_CHECK: begin
          push = 1'b1;
          if (rx_byte_i != chk_q) begin
            job.job = J_ERROR; job.code = E_CHECK;
          end else begin
            job.job = J_FINISH;
          end
          phase_d = PH_IDLE; ticks_d = '0; pos_d = '0; held_d = '0;
        end
        default: begin
          ftype_d = (rx_byte_i > 8'd5) ? 3'd7 : rx_byte_i[2:0];
          chk_d = rx_byte_i; ticks_d = '0; phase_d = PH_SEQ;
        end
      endcase
    end else if (op_i == OP_TICK && timed) begin
      if (ticks_q >= limit) begin
        push = 1'b1; job.job = J_ERROR; job.code = tcode;
        phase_d = PH_IDLE; ticks_d = '0; pos_d = '0; held_d = '0;
      end else begin
        ticks_d = ticks_q + 16'd1;
      end
    end else if (op_i == OP_DIST) begin
      dist_d = distance_in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; ftype_q <= '0; seq_q <= '0; chk_q <= '0;
      rem_q <= '0; len_q <= '0; pos_q <= '0; held_q <= '0;
      ticks_q <= '0; dist_q <= '0;
    end else if (acc) begin
      phase_q <= phase_d; ftype_q <= ftype_d; seq_q <= seq_d; chk_q <= chk_d;
      rem_q <= rem_d; len_q <= len_d; pos_q <= pos_d; held_q <= held_d;
      ticks_q <= ticks_d; dist_q <= dist_d;
    end
  end

`ifndef SYNTHESIS
  a_fixed_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_FIXED |-> pos_q != 2'd3) else $error("fixed byte count overrun");
  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> ticks_q == 16'd0 && pos_q == 2'd0)
    else $error("idle with stale timer");
  a_push_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_o |-> job_ready_i) else $error("job pushed into full queue");
`endif
endmodule

// File: hdl/fcr_queue.sv
// ----------------------------------------------------------------------------
// fcr_queue: job queue
// Small first-in first-out buffer between parser and sequencer.
// ----------------------------------------------------------------------------
module fcr_queue #(
  parameter int Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fcr_pkg::job_t  data_i,
  output logic           ready_o,
  output logic           valid_o,
  output fcr_pkg::job_t  data_o,
  input  logic           pop_i
);
  import fcr_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  job_t              mem_q [Depth];
  logic [AW-1:0]     wr_q, rd_q;
  logic [AW:0]       cnt_q;
  logic              do_push, do_pop;

  assign ready_o = cnt_q != Depth[AW:0];
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + {{AW{1'b0}}, do_push} - {{AW{1'b0}}, do_pop};
    end
  end

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Depth[AW:0]) else $error("queue count overflow");
  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> ready_o) else $error("push while full");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");
`endif
endmodule

// File: hdl/fcr_back.sv
// ----------------------------------------------------------------------------
// fcr_back: result sequencer
// Expands one job into its run of result beats, one beat per cycle
// while the output is not stalled, through an output register.
// ----------------------------------------------------------------------------
module fcr_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  input  fcr_pkg::job_t    job_i,
  output logic             job_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output fcr_pkg::result_t res_o
);
  import fcr_pkg::*;

  logic [2:0] idx_q, idx_d;
  logic [2:0] total;
  result_t    res_q, beat;
  logic       vld_q;
  logic       load;
  logic [7:0] ft8, hi, lo;

  assign ft8 = {5'd0, job_i.ftype};
  assign hi = job_i.range_mm[15:8];
  assign lo = job_i.range_mm[7:0];

  always_comb begin
    beat = '0;
    total = 3'd1;
    case (job_i.job)
      J_TEXT: begin beat.kind = K_TEXT; beat.reply_value = job_i.val; end
      J_NOTE: begin
        beat.kind = K_NOTE;
        beat.word_first = job_i.held[23:8];
        beat.word_second = {job_i.held[7:0], job_i.val};
      end
      J_ERROR: begin
        if (job_i.ftype == 3'd2 || job_i.ftype == 3'd3) total = 3'd2;
        if (idx_q == 3'd0) begin
          beat.kind = K_ERROR; beat.error_code = job_i.code;
        end else begin
          beat.kind = K_DISCARD;
        end
      end
      default: begin
        if (job_i.ftype == 3'd0) begin
          total = 3'd5;
          beat.kind = K_REPLY;
          case (idx_q)
            3'd0: beat.reply_value = ft8;
            3'd1: beat.reply_value = job_i.seq;
            3'd2: beat.reply_value = hi;
            3'd3: beat.reply_value = lo;
            default: beat.reply_value = ft8 ^ job_i.seq ^ hi ^ lo;
          endcase
        end else begin
          total = 3'd4;
          if (idx_q == 3'd0) begin
            case (job_i.ftype)
              3'd1: begin
                beat.kind = K_POS;
                beat.word_first = {8'd0, job_i.held[23:16]};
                beat.word_second = {8'd0, job_i.held[15:8]};
                beat.heading = job_i.held[7:0];
              end
              3'd2: begin beat.kind = K_TCOMMIT; beat.item_count = job_i.count; end
              3'd3: begin beat.kind = K_MCOMMIT; beat.item_count = job_i.count; end
              default: begin
                beat.kind = (job_i.ftype == 3'd4) ? K_CAM : K_VICTIM;
                beat.red = job_i.held[23:16];
                beat.green = job_i.held[15:8];
                beat.blue = job_i.held[7:0];
              end
            endcase
          end else begin
            beat.kind = K_REPLY;
            case (idx_q)
              3'd1: beat.reply_value = ft8;
              3'd2: beat.reply_value = job_i.seq;
              default: beat.reply_value = ft8 ^ job_i.seq;
            endcase
          end
        end
      end
    endcase
    beat.last = (idx_q == total - 3'd1);
  end

  assign load = job_valid_i && (!vld_q || out_ready_i);
  assign job_pop_o = load && beat.last;
  assign idx_d = beat.last ? 3'd0 : idx_q + 3'd1;
  assign out_valid_o = vld_q;
  assign res_o = res_q;

  always_ff @(posedge clk_i) begin
    if (load) res_q <= beat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0; idx_q <= '0;
    end else begin
      if (load) begin
        vld_q <= 1'b1; idx_q <= idx_d;
      end else if (out_ready_i) begin
        vld_q <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_idx_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= 3'd4) else $error("beat index overrun");
  a_pop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |=> out_valid_o && res_o.last) else $error("pop without last beat");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(res_o)) else $error("result changed");
`endif
endmodule

// File: hdl/framed_command_receiver.sv
// ----------------------------------------------------------------------------
// framed_command_receiver: serial command frame parser
// Parses type, sequence, payload and check frames into results.
// ----------------------------------------------------------------------------
// The first result beat passes through the job queue and the output register.
// Throughput: one input beat per cycle while the job queue has room; the
// sequencer drains up to five result beats per input, one per ready cycle.
// Reset clears parser state, the queue and the output valid; timeouts
// return to 3000, 100 and 200 ticks.
module framed_command_receiver #(
  parameter int QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [15:0] distance_in_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  kind_o,
  output logic [7:0]  reply_value_o,
  output logic [15:0] word_first_o,
  output logic [15:0] word_second_o,
  output logic [7:0]  heading_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  item_count_o,
  output logic [2:0]  error_code_o,
  output logic        last_o
);
  import fcr_pkg::*;

  logic [15:0] long_q, length_q, note_q;
  job_t        fjob, qjob;
  logic        fvalid, qready, qvalid, qpop;
  result_t     res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_q <= LONG_RESET; length_q <= LENGTH_RESET; note_q <= NOTE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_LONG:   long_q <= cfg_data_i;
        REG_LENGTH: length_q <= cfg_data_i;
        REG_NOTE:   note_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fcr_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i, .rx_byte_i, .distance_in_i,
    .long_timeout_i(long_q), .length_timeout_i(length_q), .note_timeout_i(note_q),
    .job_valid_o(fvalid), .job_o(fjob), .job_ready_i(qready)
  );

  fcr_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .push_i(fvalid), .data_i(fjob), .ready_o(qready),
    .valid_o(qvalid), .data_o(qjob), .pop_i(qpop)
  );

  fcr_back u_back (
    .clk_i, .rst_ni, .job_valid_i(qvalid), .job_i(qjob), .job_pop_o(qpop),
    .out_valid_o, .out_ready_i, .res_o(res)
  );

  assign kind_o = res.kind;
  assign reply_value_o = res.reply_value;
  assign word_first_o = res.word_first;
  assign word_second_o = res.word_second;
  assign heading_o = res.heading;
  assign red_o = res.red;
  assign green_o = res.green;
  assign blue_o = res.blue;
  assign item_count_o = res.item_count;
  assign error_code_o = res.error_code;
  assign last_o = res.last;
endmodule
